// File: rtl/core/ipv4ck_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4ck_pkg
// Types, constants and ones-complement helpers for the IPv4/UDP checksum
// builder.
// ----------------------------------------------------------------------------
package ipv4ck_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned ACC_W      = 20;   // unfolded multi-term sum

    // Payload limit in bytes
    localparam logic [LEN_W-1:0] MAX_PAYLOAD   = 11'd1472;

    localparam logic [LEN_W:0]   IP_UDP_HDR_LEN = 12'd28;
    localparam logic [LEN_W:0]   UDP_HDR_LEN    = 12'd8;
    localparam logic [LEN_W:0]   IP_LEN_MAX     = 12'd1500;
    localparam logic [LEN_W:0]   UDP_LEN_MAX    = 12'd1480;

    localparam logic [15:0] IP_VER_IHL_WORD = 16'h4500;
    localparam logic [15:0] PROTO_UDP       = 16'd17;
    localparam logic [15:0] ALL_ONES        = 16'hffff;

    localparam logic [31:0] SOURCE_IP_RST   = 32'd167772161;
    localparam logic [31:0] DEST_IP_RST     = 32'd167772162;
    localparam logic [15:0] SOURCE_PORT_RST = 16'd30000;
    localparam logic [15:0] DEST_PORT_RST   = 16'd0;

    // Pre-sums of the reset register values
    localparam logic [17:0] ADDR_SUM_RST =
        18'(SOURCE_IP_RST[31:16]) + 18'(SOURCE_IP_RST[15:0]) +
        18'(DEST_IP_RST[31:16]) + 18'(DEST_IP_RST[15:0]);
    localparam logic [16:0] PORT_SUM_RST =
        17'(SOURCE_PORT_RST) + 17'(DEST_PORT_RST);

    typedef enum logic [1:0] {
        REG_SOURCE_IP   = 2'd0,
        REG_DEST_IP     = 2'd1,
        REG_SOURCE_PORT = 2'd2,
        REG_DEST_PORT   = 2'd3
    } cfg_reg_t;

    // Snapshot of the accumulator at the final byte
    typedef struct packed {
        logic [15:0]      sum;
        logic [7:0]       held;
        logic             odd;
        logic [LEN_W-1:0] count;
        logic             ovf;
    } fin_t;

    // 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    // Fold a 20-bit sum to 16 bits, end-around
    function automatic logic [15:0] oc_fold(input logic [ACC_W-1:0] x);
        logic [16:0] f;
        f = {1'b0, x[15:0]} + {13'b0, x[ACC_W-1:16]};
        return f[15:0] + {15'b0, f[16]};
    endfunction

endpackage

// File: rtl/core/ipv4_udp_checksum_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_udp_checksum_builder
// Running ones-complement sum over UDP payload bytes; gives lengths and the
// IPv4 header and UDP checksums for each datagram.
// ----------------------------------------------------------------------------
// Usage:
//   Payload channel (payload_valid/payload_ready): one byte per transfer in
//   wire order, final_byte high on the last byte of the datagram.
//   Result channel (result_valid/result_ready): one transfer per datagram
//   with both lengths, both checksums and the too_long flag.
//   APB port: source_ip, dest_ip, source_port, dest_port at 0x0/0x4/0x8/0xC.
//   Write them only while no datagram is in flight.
// Throughput: one byte per cycle while payload_ready is high; the byte sum is
//   a single end-around add.
// Result path: the final byte's sums go to the snapshot register, then to the
//   result register after the header sums, where result_valid rises.
// Bytes past the payload limit are dropped from sum and count and set
//   too_long; a final byte past the limit still closes the datagram.
// Reset: registers return to 10.0.0.1 / 10.0.0.2 / 30000 / 0 and the
//   accumulator and both pipeline stages are emptied.
// Stall: a held result keeps the snapshot stage full; payload_ready then
//   stays low for every byte until the result register drains.
// ----------------------------------------------------------------------------
module ipv4_udp_checksum_builder
    import ipv4ck_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // payload channel
    input  logic                  payload_valid,
    output logic                  payload_ready,
    input  logic [7:0]            payload_byte,
    input  logic                  final_byte,
    // result channel
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [LEN_W-1:0]      ip_total_length,
    output logic [15:0]           ip_header_checksum,
    output logic [LEN_W-1:0]      udp_length,
    output logic [15:0]           udp_checksum,
    output logic                  too_long
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] source_ip_reg;
    logic [31:0] dest_ip_reg;
    logic [15:0] source_port_reg;
    logic [15:0] dest_port_reg;
    // Pre-sums of the static header words, so the final stage adds few terms
    logic [17:0] addr_sum_reg;
    logic [16:0] port_sum_reg;

    logic     cfg_write;
    cfg_reg_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_ip_reg   <= SOURCE_IP_RST;
            dest_ip_reg     <= DEST_IP_RST;
            source_port_reg <= SOURCE_PORT_RST;
            dest_port_reg   <= DEST_PORT_RST;
            addr_sum_reg    <= ADDR_SUM_RST;
            port_sum_reg    <= PORT_SUM_RST;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_sel)
                    REG_SOURCE_IP:   source_ip_reg   <= pwdata;
                    REG_DEST_IP:     dest_ip_reg     <= pwdata;
                    REG_SOURCE_PORT: source_port_reg <= pwdata[15:0];
                    REG_DEST_PORT:   dest_port_reg   <= pwdata[15:0];
                    default:         ;
                endcase
            end
            // Next cycle after a write; user must write only while idle, unenforced
            addr_sum_reg <= 18'(source_ip_reg[31:16]) + 18'(source_ip_reg[15:0]) +
                            18'(dest_ip_reg[31:16]) + 18'(dest_ip_reg[15:0]);
            port_sum_reg <= 17'(source_port_reg) + 17'(dest_port_reg);
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_SOURCE_IP:   prdata = source_ip_reg;
            REG_DEST_IP:     prdata = dest_ip_reg;
            REG_SOURCE_PORT: prdata = {16'b0, source_port_reg};
            REG_DEST_PORT:   prdata = {16'b0, dest_port_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic fin_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic byte_fire;

    assign out_load      = fin_valid_reg && (!out_valid_reg || result_ready);
    assign payload_ready = !fin_valid_reg || out_load;
    assign byte_fire     = payload_valid && payload_ready;
    assign result_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_fire && final_byte)
                fin_valid_reg <= 1'b1;
            else if (out_load)
                fin_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Byte accumulator
    // ------------------------------------------------------------------
    logic [15:0]      sum_reg,   sum_next;
    logic [7:0]       held_reg,  held_next;
    logic             odd_reg,   odd_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg,   ovf_next;

    always_comb
    begin
        sum_next   = sum_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (count_reg < MAX_PAYLOAD)
        begin
            if (odd_reg)
            begin
                sum_next  = oc_add(sum_reg, {held_reg, payload_byte});
                held_next = 8'h00;
                odd_next  = 1'b0;
            end
            else
            begin
                held_next = payload_byte;
                odd_next  = 1'b1;
            end
            count_next = count_reg + 1'b1;
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            held_reg  <= '0;
            odd_reg   <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (byte_fire)
        begin
            if (final_byte)
            begin
                // datagram closes; start the next one clean
                sum_reg   <= '0;
                held_reg  <= '0;
                odd_reg   <= 1'b0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                held_reg  <= held_next;
                odd_reg   <= odd_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Snapshot stage
    // ------------------------------------------------------------------
    fin_t fin_reg;

    always_ff @(posedge clk)
    begin
        if (byte_fire && final_byte)
        begin
            fin_reg.sum   <= sum_next;
            fin_reg.held  <= held_next;
            fin_reg.odd   <= odd_next;
            fin_reg.count <= count_next;
            fin_reg.ovf   <= ovf_next;
        end
    end

    // ------------------------------------------------------------------
    // Header sums
    // ------------------------------------------------------------------
    logic [15:0]      pay_sum;
    logic [LEN_W:0]   ip_len_raw;
    logic [LEN_W:0]   udp_len_raw;
    logic [LEN_W-1:0] ip_len;
    logic [LEN_W-1:0] udp_len;
    logic [ACC_W-1:0] ip_acc;
    logic [ACC_W-1:0] udp_acc;
    logic [15:0]      ip_ck;
    logic [15:0]      udp_ck_raw;
    logic [15:0]      udp_ck;

    always_comb
    begin
        // odd length: pad the held byte with a zero low byte
        pay_sum = oc_add(fin_reg.sum, fin_reg.odd ? {fin_reg.held, 8'h00} : 16'h0000);

        ip_len_raw  = {1'b0, fin_reg.count} + IP_UDP_HDR_LEN;
        udp_len_raw = {1'b0, fin_reg.count} + UDP_HDR_LEN;
        ip_len  = (ip_len_raw  > IP_LEN_MAX)  ? IP_LEN_MAX[LEN_W-1:0]  : ip_len_raw[LEN_W-1:0];
        udp_len = (udp_len_raw > UDP_LEN_MAX) ? UDP_LEN_MAX[LEN_W-1:0] : udp_len_raw[LEN_W-1:0];

        ip_acc = ACC_W'(IP_VER_IHL_WORD) + ACC_W'(PROTO_UDP) + ACC_W'(ip_len) +
                 ACC_W'(addr_sum_reg);
        ip_ck  = ~oc_fold(ip_acc);

        // UDP length counts twice: pseudo-header and UDP header
        udp_acc = ACC_W'(addr_sum_reg) + ACC_W'(PROTO_UDP) + ACC_W'(udp_len) +
                  ACC_W'(udp_len) + ACC_W'(port_sum_reg) + ACC_W'(pay_sum);
        udp_ck_raw = ~oc_fold(udp_acc);
        udp_ck     = (udp_ck_raw == 16'h0000) ? ALL_ONES : udp_ck_raw;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ip_total_length    <= ip_len;
            ip_header_checksum <= ip_ck;
            udp_length         <= udp_len;
            udp_checksum       <= udp_ck;
            too_long           <= fin_reg.ovf;
        end
    end

endmodule

// File: rtl/core/ipv4ck_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4ck_checker
// Port-level assertions for the IPv4/UDP checksum builder, bound to the top.
// ----------------------------------------------------------------------------
module ipv4ck_checker
    import ipv4ck_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input logic [LEN_W-1:0] ip_total_length,
    input logic [LEN_W-1:0] udp_length,
    input logic [15:0]      udp_checksum,
    input logic             too_long
);

    // A stalled result stays valid and holds its UDP checksum and IPv4 length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(udp_checksum)
            && $stable(ip_total_length))
        else $error("result changed while stalled");

    // IPv4 length is always the UDP length plus the IPv4 header
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ip_total_length == udp_length + 11'd20)
        else $error("IPv4 and UDP lengths disagree");

    // A zero UDP checksum is never sent
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> udp_checksum != 16'h0000)
        else $error("zero UDP checksum sent");

    // Overflow means the count stopped at the payload limit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && too_long |-> udp_length == MAX_PAYLOAD + 11'd8)
        else $error("too_long with short length");

endmodule

bind ipv4_udp_checksum_builder ipv4ck_checker u_ipv4ck_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .ip_total_length (ip_total_length),
    .udp_length      (udp_length),
    .udp_checksum    (udp_checksum),
    .too_long        (too_long)
);
